@@ sv/pcd_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG chunk deframer package
// Request types, status codes and file-format constants shared by the
// deframer modules.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int SigLen = 8;
    localparam int IhdrLen = 13;
    localparam int IhdrTail = 5;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_CHUNK_DONE = 2'd0;
    localparam status_t STATUS_BAD_SIG    = 2'd1;
    localparam status_t STATUS_TRUNCATED  = 2'd2;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    localparam logic [7:0] SIG_BYTES [SigLen] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic [31:0] chunk_crc;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  bit_depth;
        logic [7:0]  color_type;
        logic [7:0]  compression_method;
        logic [7:0]  filter_method;
        logic [7:0]  interlace_method;
        logic        is_end_chunk;
    } out_item_t;

endpackage

@@ sv/pcd_in_stage.sv @@
// ----------------------------------------------------------------------------
// PNG chunk deframer input register
// Registers each incoming byte request and hands it to the parser, taking a
// new request in the same cycle that the held one moves on.
// ----------------------------------------------------------------------------
module pcd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcd_pkg::in_item_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output pcd_pkg::in_item_t q_data
);
    import pcd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

@@ sv/pcd_parser.sv @@
// ----------------------------------------------------------------------------
// PNG chunk deframer parser
// Walks the signature and chunk fields one byte per request, captures the
// image header and registers one result per completed chunk or error.
// ----------------------------------------------------------------------------
module pcd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pcd_pkg::in_item_t  in_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pcd_pkg::out_item_t m_data
);
    import pcd_pkg::*;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_IDLE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [7:0]  ihdr_reg [IhdrTail];
    logic [7:0]  ihdr_next [IhdrTail];

    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic        take;
    logic        emit;
    status_t     emit_status;
    logic        emit_last;
    logic [7:0]  b;
    logic [31:0] cnt_inc;

    assign in_ready = !m_valid_reg || m_ready;
    assign take     = in_valid && in_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign b        = in_data.data_byte;
    assign cnt_inc  = cnt_reg + 32'd1;

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        ihdr_next   = ihdr_reg;
        emit        = 1'b0;
        emit_status = STATUS_CHUNK_DONE;
        emit_last   = 1'b0;

        if (in_data.end_of_file) begin
            if (phase_reg != PH_IDLE) begin
                emit        = 1'b1;
                emit_status = STATUS_TRUNCATED;
            end
            phase_next = PH_SIG;
            cnt_next   = '0;
            len_next   = '0;
            type_next  = '0;
            crc_next   = '0;
        end else begin
            unique case (phase_reg)
                PH_SIG: begin
                    if (b != SIG_BYTES[cnt_reg[2:0]]) begin
                        emit        = 1'b1;
                        emit_status = STATUS_BAD_SIG;
                        phase_next  = PH_IDLE;
                        cnt_next    = '0;
                    end else if (cnt_reg[2:0] == 3'(SigLen - 1)) begin
                        phase_next = PH_LEN;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc[31:0];
                    end
                end
                PH_LEN: begin
                    len_next = {len_reg[23:0], b};
                    if (cnt_reg[1:0] == 2'd3) begin
                        phase_next = PH_TYPE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc[31:0];
                    end
                end
                PH_TYPE: begin
                    type_next = {type_reg[23:0], b};
                    if (cnt_reg[1:0] == 2'd3) begin
                        // A new header wipes the previous image fields.
                        if (type_next == TYPE_IHDR) begin
                            width_next  = '0;
                            height_next = '0;
                            for (int i = 0; i < IhdrTail; i++) begin
                                ihdr_next[i] = '0;
                            end
                        end
                        phase_next = (len_reg == '0) ? PH_CRC : PH_DATA;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc[31:0];
                    end
                end
                PH_DATA: begin
                    if (type_reg == TYPE_IHDR && cnt_reg < 32'(IhdrLen)) begin
                        if (cnt_reg < 32'd4) begin
                            width_next = {width_reg[23:0], b};
                        end else if (cnt_reg < 32'd8) begin
                            height_next = {height_reg[23:0], b};
                        end else begin
                            // Offsets 8 to 12 map onto entries 0 to 4.
                            ihdr_next[cnt_reg[2:0]] = b;
                        end
                    end
                    if (cnt_inc >= len_reg) begin
                        phase_next = PH_CRC;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc[31:0];
                    end
                end
                PH_CRC: begin
                    crc_next = {crc_reg[23:0], b};
                    if (cnt_reg[1:0] == 2'd3) begin
                        emit       = 1'b1;
                        emit_last  = (type_reg == TYPE_IEND);
                        phase_next = emit_last ? PH_IDLE : PH_LEN;
                        cnt_next   = '0;
                        len_next   = '0;
                        type_next  = '0;
                        crc_next   = '0;
                    end else begin
                        cnt_next = cnt_inc[31:0];
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
        end

        m_data_next.status             = emit_status;
        m_data_next.chunk_type         = (emit_status == STATUS_CHUNK_DONE) ? type_reg : '0;
        m_data_next.chunk_length       = (emit_status == STATUS_CHUNK_DONE) ? len_reg : '0;
        m_data_next.chunk_crc          = (emit_status == STATUS_CHUNK_DONE) ?
                                         {crc_reg[23:0], b} : '0;
        m_data_next.image_width        = width_next;
        m_data_next.image_height       = height_next;
        m_data_next.bit_depth          = ihdr_next[0];
        m_data_next.color_type         = ihdr_next[1];
        m_data_next.compression_method = ihdr_next[2];
        m_data_next.filter_method      = ihdr_next[3];
        m_data_next.interlace_method   = ihdr_next[4];
        m_data_next.is_end_chunk       = emit_last;

        if (take) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            cnt_reg     <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            crc_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            for (int i = 0; i < IhdrTail; i++) begin
                ihdr_reg[i] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                len_reg    <= len_next;
                type_reg   <= type_next;
                crc_reg    <= crc_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                ihdr_reg   <= ihdr_next;
            end
        end
        if (take && emit) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ sv/png_chunk_deframer.sv @@
// Input and result registers sit on each side of the parser.
// Throughput: one byte per cycle, unless m_ready holds a pending result.
// The parser's state update is the single loop that paces each byte.
// Reset: synchronous, active-low aresetn; clears the parse state and the image
// header fields and empties both registers.
// ----------------------------------------------------------------------------
// PNG chunk deframer
// Checks the PNG signature and reports each chunk's type, length and CRC,
// along with the image header fields from the latest IHDR chunk.
// ----------------------------------------------------------------------------
module png_chunk_deframer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pcd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pcd_pkg::out_item_t m_data
);
    import pcd_pkg::*;

    logic     q_valid;
    logic     q_ready;
    in_item_t q_data;

    pcd_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    pcd_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// PNG chunk deframer testbench
// Streams short directed byte sequences and then random PNG-like files
// (good, truncated and with broken signatures) through the deframer, with
// random idle cycles on both channels.  Every chunk report is checked
// against a behavioral parser kept inside the testbench.
// ----------------------------------------------------------------------------
module tb;
    import pcd_pkg::*;

    localparam int StimTarget  = 750;
    localparam int DrainCycles = 16;
    localparam int StallLimit  = 2000;
    localparam int CalmStart   = 300;
    localparam int CalmEnd     = 700;

    typedef enum logic [2:0] {
        SCAN_SIG, SCAN_LEN, SCAN_TYPE, SCAN_DATA, SCAN_CRC, SCAN_DONE
    } scan_phase_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t    pending_bytes[$];
    out_item_t   chunk_reports[$];
    logic [7:0]  file_bytes[$];
    int          stim_count = 0;
    int          mismatch_count = 0;
    int          cycle_no = 0;
    int          quiet_cycles = 0;
    logic        calm;

    // Parser state mirrored from the block.
    scan_phase_t scan_phase = SCAN_SIG;
    logic [31:0] scan_count = '0;
    logic [31:0] scan_len = '0;
    logic [31:0] scan_type = '0;
    logic [31:0] scan_crc = '0;
    logic [31:0] hdr_width = '0;
    logic [31:0] hdr_height = '0;
    logic [7:0]  hdr_tail[IhdrTail] = '{default: '0};

    png_chunk_deframer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    assign calm = (cycle_no >= CalmStart) && (cycle_no < CalmEnd);

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_no, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task automatic queue_report(input status_t st, input logic [31:0] ctype,
                                input logic [31:0] clen, input logic [31:0] crc,
                                input logic last);
        out_item_t r;
        r.status             = st;
        r.chunk_type         = ctype;
        r.chunk_length       = clen;
        r.chunk_crc          = crc;
        r.image_width        = hdr_width;
        r.image_height       = hdr_height;
        r.bit_depth          = hdr_tail[0];
        r.color_type         = hdr_tail[1];
        r.compression_method = hdr_tail[2];
        r.filter_method      = hdr_tail[3];
        r.interlace_method   = hdr_tail[4];
        r.is_end_chunk       = last;
        chunk_reports.push_back(r);
    endtask

    task automatic clear_chunk_state();
        scan_count = '0;
        scan_len   = '0;
        scan_type  = '0;
        scan_crc   = '0;
    endtask

    task automatic deframe_byte(input in_item_t req);
        logic [7:0] b;
        logic       last;
        b = req.data_byte;
        if (req.end_of_file) begin
            if (scan_phase != SCAN_DONE) begin
                queue_report(STATUS_TRUNCATED, '0, '0, '0, 1'b0);
            end
            scan_phase = SCAN_SIG;
            clear_chunk_state();
            return;
        end
        case (scan_phase)
            SCAN_SIG: begin
                if (b != SIG_BYTES[scan_count[2:0]]) begin
                    queue_report(STATUS_BAD_SIG, '0, '0, '0, 1'b0);
                    scan_phase = SCAN_DONE;
                    scan_count = '0;
                end else if (scan_count >= SigLen - 1) begin
                    scan_phase = SCAN_LEN;
                    scan_count = '0;
                end else begin
                    scan_count++;
                end
            end
            SCAN_LEN: begin
                scan_len = {scan_len[23:0], b};
                if (scan_count >= 3) begin
                    scan_phase = SCAN_TYPE;
                    scan_count = '0;
                end else begin
                    scan_count++;
                end
            end
            SCAN_TYPE: begin
                scan_type = {scan_type[23:0], b};
                if (scan_count >= 3) begin
                    // A new header wipes the previous image fields.
                    if (scan_type == TYPE_IHDR) begin
                        hdr_width  = '0;
                        hdr_height = '0;
                        hdr_tail   = '{default: '0};
                    end
                    scan_phase = (scan_len == 0) ? SCAN_CRC : SCAN_DATA;
                    scan_count = '0;
                end else begin
                    scan_count++;
                end
            end
            SCAN_DATA: begin
                if (scan_type == TYPE_IHDR && scan_count < IhdrLen) begin
                    if (scan_count < 4) begin
                        hdr_width = {hdr_width[23:0], b};
                    end else if (scan_count < 8) begin
                        hdr_height = {hdr_height[23:0], b};
                    end else begin
                        hdr_tail[scan_count - 8] = b;
                    end
                end
                if (scan_count + 32'd1 >= scan_len) begin
                    scan_phase = SCAN_CRC;
                    scan_count = '0;
                end else begin
                    scan_count++;
                end
            end
            SCAN_CRC: begin
                scan_crc = {scan_crc[23:0], b};
                if (scan_count >= 3) begin
                    last = (scan_type == TYPE_IEND);
                    queue_report(STATUS_CHUNK_DONE, scan_type, scan_len, scan_crc, last);
                    clear_chunk_state();
                    scan_phase = last ? SCAN_DONE : SCAN_LEN;
                end else begin
                    scan_count++;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_report(input out_item_t got);
        out_item_t want;
        if (chunk_reports.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
            return;
        end
        want = chunk_reports.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("chunk_type", got.chunk_type, want.chunk_type);
        compare_field("chunk_length", got.chunk_length, want.chunk_length);
        compare_field("chunk_crc", got.chunk_crc, want.chunk_crc);
        compare_field("image_width", got.image_width, want.image_width);
        compare_field("image_height", got.image_height, want.image_height);
        compare_field("bit_depth", got.bit_depth, want.bit_depth);
        compare_field("color_type", got.color_type, want.color_type);
        compare_field("compression_method", got.compression_method,
                      want.compression_method);
        compare_field("filter_method", got.filter_method, want.filter_method);
        compare_field("interlace_method", got.interlace_method,
                      want.interlace_method);
        compare_field("is_end_chunk", got.is_end_chunk, want.is_end_chunk);
    endtask

    task automatic push_byte(input logic [7:0] b, input bit counted);
        pending_bytes.push_back('{data_byte: b, end_of_file: 1'b0});
        if (counted) stim_count++;
    endtask

    task automatic push_eof();
        pending_bytes.push_back('{data_byte: 8'($urandom), end_of_file: 1'b1});
        stim_count++;
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic add_chunk(input logic [31:0] ctype, input int clen);
        add_word(clen);
        add_word(ctype);
        repeat (clen) file_bytes.push_back(8'($urandom));
        add_word($urandom);
    endtask

    // Sends the first keep bytes of the file, then ignored filler, then the end.
    task automatic flush_file(input int keep, input int junk);
        for (int i = 0; i < keep; i++) push_byte(file_bytes[i], 1'b1);
        repeat (junk) push_byte(8'($urandom), 1'b0);
        push_eof();
    endtask

    task automatic gen_file();
        int          mode;
        int          pick;
        int          pos;
        logic [31:0] ctype;
        file_bytes.delete();
        mode = $urandom_range(99);
        for (int i = 0; i < SigLen; i++) file_bytes.push_back(SIG_BYTES[i]);
        if (mode >= 90) begin
            pos = $urandom_range(SigLen - 1);
            file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(255, 1));
            flush_file(pos + 1, $urandom_range(3));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                add_chunk(TYPE_IHDR, ($urandom_range(9) < 7) ? IhdrLen
                                                             : $urandom_range(20));
            end else if (pick < 55) begin
                add_chunk(32'h4944_4154, $urandom_range(12));
            end else begin
                add_chunk($urandom, $urandom_range(12));
            end
        end
        if (mode < 70) begin
            add_chunk(TYPE_IEND, ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0);
            flush_file(file_bytes.size(), $urandom_range(4));
        end else if ($urandom_range(2) == 0) begin
            // A chunk announcing a huge length, cut off inside its data.
            ctype = ($urandom_range(1) == 0) ? TYPE_IHDR : $urandom;
            add_word($urandom);
            add_word(ctype);
            repeat ($urandom_range(8)) file_bytes.push_back(8'($urandom));
            flush_file(file_bytes.size(), 0);
        end else begin
            flush_file($urandom_range(file_bytes.size() - 1), 0);
        end
    endtask

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) deframe_byte(s_data);
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_report(m_data);
            m_ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= StallLimit) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        // Empty file, then a wrong first byte with a trailing ignored byte.
        push_eof();
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_eof();
        // Signature wrong only in its last byte.
        for (int i = 0; i < SigLen - 1; i++) push_byte(SIG_BYTES[i], 1'b1);
        push_byte(8'h0B, 1'b1);
        push_eof();
        // File cut inside the signature.
        for (int i = 0; i < 3; i++) push_byte(SIG_BYTES[i], 1'b1);
        push_eof();
        while (stim_count < StimTarget) gen_file();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (chunk_reports.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
